// ===== design/pqb_pkg.sv =====
// ----------------------------------------------------------------------------
// pqb_pkg
// Shared constants, register codes and helper width functions for the
// piecewise quadratic Bezier path block.
// ----------------------------------------------------------------------------
package pqb_pkg;

  localparam int MAX_SEGMENTS_DEF = 4;
  localparam int COORD_BITS_DEF   = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 33;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_TICKS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_RECIPROCAL = 2'd2;

  localparam logic [15:0] TICKS_RESET = 16'd1024;
  localparam logic [2:0]  COUNT_RESET = 3'd4;
  localparam logic [32:0] RECIP_RESET = 33'h0_0040_0000;

  // Item kinds.
  localparam logic MODE_ADVANCE = 1'b1;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 4;

  // Configuration values the back end works with.
  typedef struct packed {
    logic [15:0] ticks;
    logic [32:0] recip;
  } pqb_cfg_t;

  function automatic int time_bits(input int max_seg);
    return 16 + $clog2(max_seg);
  endfunction

  function automatic int slot_bits(input int max_seg);
    return $clog2(2 * max_seg + 1);
  endfunction

  // Command word: advance flag, clamp flag, slot, point, step.
  function automatic int cmd_width(input int max_seg, input int coord_bits);
    return 2 + slot_bits(max_seg) + 3 * coord_bits + time_bits(max_seg);
  endfunction

endpackage

// ===== design/pqb_front.sv =====
// ----------------------------------------------------------------------------
// pqb_front
// Input stage: registers one item, classifies it, clamps the time step to
// one loop and drops loads to slots outside the table.
// ----------------------------------------------------------------------------
module pqb_front
  import pqb_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int TIME_BITS   = time_bits(MAX_SEGMENTS),
  localparam int SLOT_W      = slot_bits(MAX_SEGMENTS),
  localparam int CMD_W       = cmd_width(MAX_SEGMENTS, COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         mode,
  input  logic [3:0]                   point_index,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic [15:0]                  time_step,
  input  logic [TIME_BITS-1:0]         loop,
  input  logic                         cmd_full,
  output logic                         cmd_push,
  output logic [CMD_W-1:0]             cmd_data
);

  localparam int SLOTS = 2 * MAX_SEGMENTS + 1;

  typedef struct packed {
    logic                        adv;
    logic                        clamped;
    logic [SLOT_W-1:0]           slot;
    logic [3*COORD_BITS-1:0]     point;
    logic [TIME_BITS-1:0]        step;
  } cmd_t;

  logic                  item_valid;
  logic                  item_mode;
  logic [3:0]            item_index;
  logic [3*COORD_BITS-1:0] item_point;
  logic [15:0]           item_step;

  logic is_adv;
  logic slot_ok;
  logic drop;
  logic consume;
  logic clamp;
  cmd_t cmd;

  always_comb begin
    is_adv  = (item_mode == MODE_ADVANCE);
    slot_ok = (32'(item_index) < SLOTS);
    drop    = !is_adv && !slot_ok;
    consume = item_valid && (drop || !cmd_full);
    clamp   = (32'(item_step) > 32'(loop));

    cmd.adv     = is_adv;
    cmd.clamped = clamp;
    cmd.slot    = SLOT_W'(item_index);
    cmd.point   = item_point;
    cmd.step    = clamp ? loop : TIME_BITS'(item_step);
  end

  assign full     = item_valid && !consume;
  assign cmd_push = item_valid && !drop && !cmd_full;
  assign cmd_data = CMD_W'(cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (push && !full) begin
      item_valid <= 1'b1;
      item_mode  <= mode;
      item_index <= point_index;
      item_point <= {point_z, point_y, point_x};
      item_step  <= time_step;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

endmodule

// ===== design/pqb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// pqb_cmd_queue
// Small first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module pqb_cmd_queue
  import pqb_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(CMD_DEPTH);

  logic [WIDTH-1:0] slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full     = (32'(count) == CMD_DEPTH);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/pqb_back.sv =====
// ----------------------------------------------------------------------------
// pqb_back
// Execution stage: holds the control point table and the path time, wraps
// time, finds the segment, and evaluates the curve with one shared
// multiplier into a result register.
// ----------------------------------------------------------------------------
module pqb_back
  import pqb_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int TIME_BITS   = time_bits(MAX_SEGMENTS),
  localparam int CMD_W       = cmd_width(MAX_SEGMENTS, COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CMD_W-1:0]             cmd_data,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  input  pqb_cfg_t                     cfg,
  input  logic [TIME_BITS-1:0]         loop,
  output logic                         res_valid,
  input  logic                         res_pop,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic [1:0]                   segment_number,
  output logic                         step_clamped
);

  localparam int SLOT_W = slot_bits(MAX_SEGMENTS);
  localparam int SLOTS  = 2 * MAX_SEGMENTS + 1;
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(TIME_BITS + 1);
  localparam int D_W    = 2 * TIME_BITS + 1;
  localparam int B_W    = (COORD_BITS > 18) ? COORD_BITS : 18;
  localparam int PROD_W = 34 + B_W;
  localparam int ACC_W  = COORD_BITS + 34;
  localparam int RQ_W   = ACC_W - 32;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32'h8000_0000);
  localparam logic signed [RQ_W-1:0]  COORD_HI   =
    RQ_W'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [RQ_W-1:0]  COORD_LO   = ~COORD_HI;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MOD    = 4'd1;
  localparam logic [3:0] ST_SEG    = 4'd2;
  localparam logic [3:0] ST_MUL_U  = 4'd3;
  localparam logic [3:0] ST_WAIT_U = 4'd4;
  localparam logic [3:0] ST_WV     = 4'd5;
  localparam logic [3:0] ST_WUV    = 4'd6;
  localparam logic [3:0] ST_WUU    = 4'd7;
  localparam logic [3:0] ST_READ   = 4'd8;
  localparam logic [3:0] ST_MAC    = 4'd9;
  localparam logic [3:0] ST_DRAIN  = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_W0   = 3'd1;
  localparam logic [2:0] TAG_W1   = 3'd2;
  localparam logic [2:0] TAG_W2   = 3'd3;
  localparam logic [2:0] TAG_ACC  = 3'd4;

  typedef struct packed {
    logic                        adv;
    logic                        clamped;
    logic [SLOT_W-1:0]           slot;
    logic [3*COORD_BITS-1:0]     point;
    logic [TIME_BITS-1:0]        step;
  } cmd_t;

  cmd_t cmd;
  assign cmd = cmd_t'(cmd_data);

  // Rounds a blended sum to the nearest coordinate and saturates it.
  function automatic logic signed [COORD_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] r;
    logic signed [RQ_W-1:0]  q;
    r = a + ROUND_HALF;
    q = r[ACC_W-1:32];
    if (q > COORD_HI) begin
      q = COORD_HI;
    end else if (q < COORD_LO) begin
      q = COORD_LO;
    end
    return COORD_BITS'(q);
  endfunction

  logic [3:0]            state;
  logic [TIME_BITS-1:0]  path_time;
  logic [TIME_BITS:0]    rem;
  logic [D_W-1:0]        div;
  logic [CNT_W-1:0]      cnt;
  logic [TIME_BITS-1:0]  s_reg;
  logic [SEG_W-1:0]      seg;
  logic                  clamped_r;
  logic [15:0]           u;
  logic [32:0]           w0;
  logic [32:0]           w1;
  logic [32:0]           w2;
  logic [1:0]            k;
  logic [1:0]            c;

  logic signed [PROD_W-1:0] prod;
  logic [2:0]               tag;
  logic [1:0]               tag_c;
  logic                     tag_first;
  logic signed [ACC_W-1:0]  acc [3];

  logic [3*COORD_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]        mem_valid;
  logic [3*COORD_BITS-1:0] rd;
  logic                    rd_valid;

  logic [TIME_BITS:0]          sum;
  logic                        stale;
  logic                        rem_ge;
  logic [TIME_BITS:0]          rem_next;
  logic [15:0]                 s16;
  logic [48:0]                 u_full;
  logic [32:0]                 u_q;
  logic [15:0]                 u_sat;
  logic [16:0]                 v;
  logic [SLOT_W-1:0]           rd_addr;
  logic [3*COORD_BITS-1:0]     rd_point;
  logic signed [COORD_BITS-1:0] coord_c;
  logic [32:0]                 mul_a;
  logic signed [B_W-1:0]       mul_b;
  logic [2:0]                  tag_next;
  logic                        load_now;

  assign cmd_pop  = (state == ST_IDLE) && !cmd_empty;
  assign load_now = cmd_pop && !cmd.adv;

  always_comb begin
    sum      = {1'b0, path_time} + {1'b0, cmd.step};
    stale    = (path_time >= loop);
    rem_ge   = (D_W'(rem) >= div);
    rem_next = rem_ge ? (rem - (TIME_BITS+1)'(div)) : rem;

    s16    = s_reg[15:0];
    u_full = {1'b0, prod[47:0]} + (cfg.recip[32] ? {1'b0, s16, 32'h0} : 49'h0);
    u_q    = u_full[48:16];
    u_sat  = (|u_q[32:16]) ? 16'hFFFF : u_q[15:0];
    v      = 17'h1_0000 - {1'b0, u};

    rd_addr  = SLOT_W'({seg, 1'b0}) + SLOT_W'(k);
    rd_point = rd_valid ? rd : '0;
    case (c)
      2'd0:    coord_c = rd_point[COORD_BITS-1:0];
      2'd1:    coord_c = rd_point[2*COORD_BITS-1:COORD_BITS];
      default: coord_c = rd_point[3*COORD_BITS-1:2*COORD_BITS];
    endcase

    mul_a    = '0;
    mul_b    = '0;
    tag_next = TAG_NONE;
    case (state)
      ST_MUL_U: begin
        mul_a = {1'b0, cfg.recip[31:0]};
        mul_b = B_W'(s16);
      end
      ST_WV: begin
        mul_a    = 33'(v);
        mul_b    = B_W'(v);
        tag_next = TAG_W0;
      end
      ST_WUV: begin
        mul_a    = 33'(v);
        mul_b    = B_W'(u);
        tag_next = TAG_W1;
      end
      ST_WUU: begin
        mul_a    = 33'(u);
        mul_b    = B_W'(u);
        tag_next = TAG_W2;
      end
      ST_MAC: begin
        case (k)
          2'd0:    mul_a = w0;
          2'd1:    mul_a = w1;
          default: mul_a = w2;
        endcase
        mul_b    = B_W'(coord_c);
        tag_next = TAG_ACC;
      end
      default: begin
        tag_next = TAG_NONE;
      end
    endcase
  end

  // Point table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (load_now) begin
      mem[cmd.slot] <= cmd.point;
    end
    if (state == ST_READ) begin
      rd       <= mem[rd_addr];
      rd_valid <= mem_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (load_now) begin
      mem_valid[cmd.slot] <= 1'b1;
    end
  end

  // Shared multiplier and the capture of its products.
  always_ff @(posedge clk) begin
    prod      <= $signed({1'b0, mul_a}) * mul_b;
    tag_c     <= c;
    tag_first <= (k == 2'd0);
    case (tag)
      TAG_W0:  w0 <= prod[32:0];
      TAG_W1:  w1 <= {prod[31:0], 1'b0};
      TAG_W2:  w2 <= prod[32:0];
      TAG_ACC: begin
        acc[tag_c] <= tag_first ? ACC_W'(prod) : acc[tag_c] + ACC_W'(prod);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= TAG_NONE;
    end else begin
      tag <= tag_next;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      path_time <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.adv) begin
            rem       <= sum;
            div       <= stale ? (D_W'(loop) << TIME_BITS) : D_W'(loop);
            cnt       <= stale ? CNT_W'(TIME_BITS) : '0;
            clamped_r <= cmd.clamped;
            state     <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem <= rem_next;
          div <= div >> 1;
          if (cnt == '0) begin
            path_time <= TIME_BITS'(rem_next);
            s_reg     <= TIME_BITS'(rem_next);
            seg       <= '0;
            state     <= ST_SEG;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SEG: begin
          if (s_reg >= TIME_BITS'(cfg.ticks)) begin
            s_reg <= s_reg - TIME_BITS'(cfg.ticks);
            seg   <= seg + 1'b1;
          end else begin
            state <= ST_MUL_U;
          end
        end
        ST_MUL_U: begin
          state <= ST_WAIT_U;
        end
        ST_WAIT_U: begin
          u     <= u_sat;
          state <= ST_WV;
        end
        ST_WV: begin
          state <= ST_WUV;
        end
        ST_WUV: begin
          state <= ST_WUU;
        end
        ST_WUU: begin
          k     <= 2'd0;
          state <= ST_READ;
        end
        ST_READ: begin
          c     <= 2'd0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          c <= c + 1'b1;
          if (c == 2'd2) begin
            if (k == 2'd2) begin
              state <= ST_DRAIN;
            end else begin
              k     <= k + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res_pop) begin
            res_valid      <= 1'b1;
            pos_x          <= round_sat(acc[0]);
            pos_y          <= round_sat(acc[1]);
            pos_z          <= round_sat(acc[2]);
            segment_number <= 2'(seg);
            step_clamped   <= clamped_r;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/piecewise_quadratic_bezier_path.sv =====
// ----------------------------------------------------------------------------
// piecewise_quadratic_bezier_path
// A load passes through the front end's holding register and the command queue
// into the point table; an advance also runs the back end's wrap, segment,
// weight and product states before its result is registered. Throughput: one
// load per cycle while the back end is idle and the command queue has room; an
// advance holds the back end until its result is registered, set by its single
// shared multiplier (13 products per advance). A wrap after a register change
// that left the time at or beyond the loop runs the full bit-serial remainder.
// Reset (synchronous, rst high): time to zero, all points read as zero,
// registers to their defaults, queues empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
//
// The block is split into a front end that takes each item transfer into a
// holding register, clamps the time step to one loop and throws away loads
// to slots outside the table, and a back end that carries the commands out in
// order. A four-entry command queue sits between them, so new items are taken
// while the back end is still busy or its result waits to be popped.
//
// The back end keeps the control point table with one valid bit per slot, so
// a slot that was never loaded reads as zero. Each advance wraps the path
// time with a compare and subtract (or a full bit-serial remainder when the
// stored time is stale), steps through segments by repeated subtraction of
// the segment length, forms the curve parameter from the reciprocal, and then
// runs the weights and the nine weight-times-coordinate products through one
// registered multiplier into three accumulators.
//
module piecewise_quadratic_bezier_path
  import pqb_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,

  // Item side.
  input  logic                         push,
  output logic                         full,
  input  logic                         mode,
  input  logic [3:0]                   point_index,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic [15:0]                  time_step,

  // Result side.
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic [1:0]                   segment_number,
  output logic                         step_clamped,

  // Register writes.
  input  logic                         cfg_write,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int TIME_BITS = time_bits(MAX_SEGMENTS);
  localparam int CMD_W     = cmd_width(MAX_SEGMENTS, COORD_BITS);
  localparam int CE_W      = $clog2(MAX_SEGMENTS + 1);

  // Configuration registers.
  logic [15:0] segment_ticks;
  logic [2:0]  segment_count;
  logic [32:0] segment_reciprocal;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_ticks      <= TICKS_RESET;
      segment_count      <= COUNT_RESET;
      segment_reciprocal <= RECIP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEGMENT_TICKS:      segment_ticks      <= cfg_data[15:0];
        CFG_SEGMENT_COUNT:      segment_count      <= cfg_data[2:0];
        CFG_SEGMENT_RECIPROCAL: segment_reciprocal <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective values: a zero length counts as one tick, and the segment
  // count is held between one and the largest supported count.
  logic [15:0]             ticks_eff;
  logic [CE_W-1:0]         count_eff;
  logic [16+CE_W-1:0]      loop_full;
  logic [TIME_BITS-1:0]    loop;
  pqb_cfg_t                cfg;

  always_comb begin
    ticks_eff = (segment_ticks == 16'd0) ? 16'd1 : segment_ticks;
    if (segment_count == 3'd0) begin
      count_eff = CE_W'(1);
    end else if (32'(segment_count) > MAX_SEGMENTS) begin
      count_eff = CE_W'(MAX_SEGMENTS);
    end else begin
      count_eff = CE_W'(segment_count);
    end
    loop_full = ticks_eff * count_eff;
    loop      = loop_full[TIME_BITS-1:0];
    cfg.ticks = ticks_eff;
    cfg.recip = segment_reciprocal;
  end

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_in;
  logic             cmd_full;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_out;
  logic             cmd_empty;
  logic             res_valid;

  pqb_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .time_step   (time_step),
    .loop        (loop),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_in)
  );

  pqb_cmd_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  pqb_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_data       (cmd_out),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .cfg            (cfg),
    .loop           (loop),
    .res_valid      (res_valid),
    .res_pop        (pop),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .segment_number (segment_number),
    .step_clamped   (step_clamped)
  );

  assign empty = !res_valid;

endmodule

// ===== design/pqb_checker.sv =====
// ----------------------------------------------------------------------------
// pqb_checker
// Port-level checks for the Bezier path block, bound to its top level.
// ----------------------------------------------------------------------------
module pqb_checker
  import pqb_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic signed [COORD_BITS-1:0] pos_x,
  input logic signed [COORD_BITS-1:0] pos_y,
  input logic signed [COORD_BITS-1:0] pos_z,
  input logic [1:0]                   segment_number,
  input logic                         step_clamped
);

  // Reset leaves no result and no held item.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not clear after reset");

  // The input side only backs up once an item has been taken in.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> ($past(full) || $past(push)))
    else $error("full raised without a prior transfer");

  // A waiting result holds until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(pos_y) &&
                          $stable(pos_z) && $stable(segment_number) &&
                          $stable(step_clamped)))
    else $error("waiting result changed");

  // The reported segment lies below MAX_SEGMENTS (checked only when it is at most four).
  a_segment_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((MAX_SEGMENTS > 4) || (32'(segment_number) < MAX_SEGMENTS)))
    else $error("segment number out of range");

endmodule

bind piecewise_quadratic_bezier_path pqb_checker #(
  .MAX_SEGMENTS (MAX_SEGMENTS),
  .COORD_BITS   (COORD_BITS)
) u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: piecewise quadratic Bezier path testbench
// Drives load and advance items into the path block through its queue-style
// item port and checks every reported position against an in-house model of
// the point table, the looping path time and the Bezier blend. The run steps
// through several register settings, including the extremes and out-of-range
// values, with phases of random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import pqb_pkg::*;

  localparam logic MODE_LOAD = ~MODE_ADVANCE;
  localparam int POINT_SLOTS = 2 * MAX_SEGMENTS_DEF + 1;

  // Quiet cycles before a register write or the end of the run. Covers the
  // longest advance, with the stale-time remainder, plus any loads still crossing
  // the command queue.
  localparam int SETTLE_CYCLES   = 200;
  // Length of the one long receiver hold that backs the block up.
  localparam int HOLD_CYCLES     = 400;
  // Cycles without any transfer or register write before the run is abandoned.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 60;

  localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  localparam longint ROUND_HALF = 64'sh0000_0000_8000_0000;

  // One input item as it appears on the item ports.
  typedef struct {
    logic              kind;
    logic [3:0]        slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]       step;
  } path_item_t;

  // One reported position.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]        seg;
    logic              clamped;
  } path_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    push = 1'b0;
  logic                    full;
  logic                    mode = MODE_LOAD;
  logic [3:0]              point_index = '0;
  logic signed [15:0]      point_x = '0;
  logic signed [15:0]      point_y = '0;
  logic signed [15:0]      point_z = '0;
  logic [15:0]             time_step = '0;

  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [15:0]      pos_x;
  logic signed [15:0]      pos_y;
  logic signed [15:0]      pos_z;
  logic [1:0]              segment_number;
  logic                    step_clamped;

  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = CFG_SEGMENT_TICKS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Mirror of the block's state, updated at each accepted transfer.
  logic [15:0]             cfg_ticks = TICKS_RESET;
  logic [2:0]              cfg_count = COUNT_RESET;
  longint unsigned         cfg_recip = RECIP_RESET;
  longint unsigned         path_time_q = 0;
  logic signed [15:0]      point_table [POINT_SLOTS][3];

  path_item_t pending_items[$];
  path_pos_t  expected_positions[$];
  path_item_t offered_item;
  path_pos_t  want_pos;

  // Items queued but not yet taken by the block.
  int items_waiting = 0;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  piecewise_quadratic_bezier_path uut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .point_index    (point_index),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .time_step      (time_step),
    .empty          (empty),
    .pop            (pop),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .segment_number (segment_number),
    .step_clamped   (step_clamped),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Ticks per segment as the block uses them: a zero register acts as one.
  function automatic longint unsigned seg_ticks_used();
    return (cfg_ticks == 0) ? 1 : cfg_ticks;
  endfunction

  // Loop length in ticks, with the segment count pulled into 1..MAX_SEGMENTS.
  function automatic longint unsigned loop_length();
    longint unsigned count;
    count = cfg_count;
    if (count == 0) count = 1;
    if (count > MAX_SEGMENTS_DEF) count = MAX_SEGMENTS_DEF;
    return seg_ticks_used() * count;
  endfunction

  // Weighted sum of one coordinate over the three points of a segment. The
  // weights sum to 2^32, so rounding is adding half and shifting by 32.
  function automatic logic signed [15:0] blend_coord(input int c, input int base,
                                                     input longint w0, input longint w1,
                                                     input longint w2);
    longint acc;
    longint q;
    acc = w0 * longint'(point_table[base][c]) + w1 * longint'(point_table[base + 1][c])
        + w2 * longint'(point_table[base + 2][c]);
    q = (acc + ROUND_HALF) >>> 32;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Advance the path time by one step and work out the position it lands on.
  function automatic path_pos_t advance_path(input logic [15:0] step_in);
    longint unsigned ticks, loop, step, t, seg, s, u, v;
    longint w0, w1, w2;
    path_pos_t r;
    ticks = seg_ticks_used();
    loop = loop_length();
    step = step_in;
    r.clamped = 1'b0;
    if (step > loop) begin
      step = loop;
      r.clamped = 1'b1;
    end
    // A stale time from before a register write is folded back here too.
    t = (path_time_q + step) % loop;
    path_time_q = t;
    seg = t / ticks;
    s = t - seg * ticks;
    u = (s * cfg_recip) >> 16;
    if (u > 65535) u = 65535;
    v = 65536 - u;
    w0 = v * v;
    w1 = 2 * u * v;
    w2 = u * u;
    r.x = blend_coord(0, int'(2 * seg), w0, w1, w2);
    r.y = blend_coord(1, int'(2 * seg), w0, w1, w2);
    r.z = blend_coord(2, int'(2 * seg), w0, w1, w2);
    r.seg = seg[1:0];
    return r;
  endfunction

  // Model update for one accepted item.
  function automatic void take_item(input path_item_t it);
    if (it.kind == MODE_ADVANCE) begin
      expected_positions.insert(expected_positions.size(), advance_path(it.step));
    end else if (it.slot < POINT_SLOTS) begin
      point_table[it.slot][0] = it.x;
      point_table[it.slot][1] = it.y;
      point_table[it.slot][2] = it.z;
    end
  endfunction

  function automatic path_item_t load_item(input logic [3:0] slot, input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z);
    path_item_t it;
    it.kind = MODE_LOAD;
    it.slot = slot;
    it.x = x;
    it.y = y;
    it.z = z;
    it.step = 16'($urandom_range(65535));
    return it;
  endfunction

  function automatic path_item_t advance_item(input logic [15:0] step);
    path_item_t it;
    it.kind = MODE_ADVANCE;
    it.slot = 4'($urandom_range(15));
    it.x = 16'($urandom_range(65535));
    it.y = 16'($urandom_range(65535));
    it.z = 16'($urandom_range(65535));
    it.step = step;
    return it;
  endfunction

  // Mostly random coordinates, with the extremes mixed in now and then.
  function automatic logic signed [15:0] random_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return COORD_MAX;
    if (pick == 1) return COORD_MIN;
    if (pick == 2) return $urandom_range(1) ? 16'sd0 : -16'sd1;
    return 16'($urandom_range(65535));
  endfunction

  // Steps are shaped around the current segment and loop lengths so that the
  // segment boundaries, the exact loop and the clamp all get hit.
  function automatic logic [15:0] random_step();
    longint unsigned loop, val;
    int pick;
    loop = loop_length();
    pick = $urandom_range(99);
    if (pick < 40) val = $urandom_range(32'(seg_ticks_used()));
    else if (pick < 60) val = loop - $urandom_range(1);
    else if (pick < 70) val = loop + 1;
    else val = $urandom_range(65535);
    return (val > 65535) ? 16'hFFFF : val[15:0];
  endfunction

  function automatic path_item_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return advance_item(random_step());
    if (pick < 95) return load_item(4'($urandom_range(POINT_SLOTS - 1)), random_coord(),
                                    random_coord(), random_coord());
    return load_item(4'($urandom_range(15, POINT_SLOTS)), random_coord(), random_coord(),
                     random_coord());
  endfunction

  task automatic queue_item(input path_item_t it);
    pending_items.insert(pending_items.size(), it);
    items_waiting++;
  endtask

  // One register write; the model follows at once since nothing is in flight.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input longint unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SEGMENT_TICKS:      cfg_ticks = value[15:0];
      CFG_SEGMENT_COUNT:      cfg_count = value[2:0];
      CFG_SEGMENT_RECIPROCAL: cfg_recip = value[CFG_DATA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_path(input longint unsigned ticks, input longint unsigned count,
                          input longint unsigned recip);
    write_register(CFG_SEGMENT_TICKS, ticks);
    write_register(CFG_SEGMENT_COUNT, count);
    write_register(CFG_SEGMENT_RECIPROCAL, recip);
  endtask

  // Wait until every queued item has been taken and every result popped, then
  // let the block run dry. A stale count here only makes the wait longer.
  task automatic wait_drained();
    while (items_waiting != 0 || expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sender: the item on the ports is modeled at the edge that transfers it,
  // and the next one is offered unless this cycle is picked as a gap.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_item(offered_item);
        items_waiting--;
      end
      if (!push || !full) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          push <= 1'b1;
          mode <= offered_item.kind;
          point_index <= offered_item.slot;
          point_x <= offered_item.x;
          point_y <= offered_item.y;
          point_z <= offered_item.z;
          time_step <= offered_item.step;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each popped position against the oldest expectation and
  // stalls at random, or for one long hold when asked to.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x %0d y %0d z %0d seg %0d",
                   $time, pos_x, pos_y, pos_z, segment_number);
          error_count++;
        end else begin
          want_pos = expected_positions.pop_front();
          check_field("pos_x", want_pos.x, pos_x);
          check_field("pos_y", want_pos.y, pos_y);
          check_field("pos_z", want_pos.z, pos_z);
          check_field("segment_number", want_pos.seg, segment_number);
          check_field("step_clamped", want_pos.clamped, step_clamped);
        end
      end
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transfer or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int p;
    int counted;
    path_item_t it;
    for (i = 0; i < POINT_SLOTS; i++) begin
      point_table[i][0] = '0;
      point_table[i][1] = '0;
      point_table[i][2] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (1024 ticks, four segments).
    // An advance before any load must read the empty table as zeros.
    queue_item(advance_item(16'd0));
    for (i = 0; i < POINT_SLOTS; i++) begin
      queue_item(load_item(4'(i), i[0] ? COORD_MIN : COORD_MAX, i[1] ? COORD_MIN : COORD_MAX,
                           16'(i * 4000 - 16000)));
    end
    // Loads to slots past the table are dropped by the block.
    queue_item(load_item(4'd9, COORD_MIN, COORD_MIN, COORD_MIN));
    queue_item(load_item(4'd15, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_item(advance_item(16'd512));
    queue_item(advance_item(16'd512));
    queue_item(advance_item(16'd1023));
    queue_item(advance_item(16'd1));
    // A step of exactly one loop is not clamped; one tick more is.
    queue_item(advance_item(16'd4096));
    queue_item(advance_item(16'd4097));
    queue_item(advance_item(16'hFFFF));
    queue_item(advance_item(16'd3000));
    queue_item(advance_item(16'd2048));
    wait_drained();

    // Random phases, each under its own register setting and idling pattern.
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      case (p)
        // A one-tick loop makes any leftover time stale.
        0: set_path(1, 1, 64'h1_0000_0000);
        1: set_path(65535, 4, 65537);
        // Zero ticks, zero segments and a zero reciprocal.
        2: set_path(0, 0, 0);
        // Segment count beyond the table acts as the maximum.
        3: set_path(300, 7, 64'h1_0000_0000 / 300);
        // Oversized reciprocal: the curve parameter saturates.
        4: set_path(1000, 3, 64'h1_FFFF_FFFF);
        5: set_path(777, 2, 64'h1_0000_0000 / 777);
        6: set_path(2, 5, 64'h8000_0000);
        default: set_path(TICKS_RESET, COUNT_RESET, RECIP_RESET);
      endcase
      // With the sender never idle, one long receiver hold backs up the
      // command queue until the block stops taking items.
      if (p == 4) hold_request = 1'b1;
      // Fill the whole table first so the advances blend real points.
      for (i = 0; i < POINT_SLOTS; i++) begin
        queue_item(load_item(4'(i), random_coord(), random_coord(), random_coord()));
      end
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        queue_item(it);
        if (it.kind == MODE_ADVANCE || it.slot < POINT_SLOTS) counted++;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pqb_pkg.sv
design/pqb_front.sv
design/pqb_cmd_queue.sv
design/pqb_back.sv
design/piecewise_quadratic_bezier_path.sv
design/pqb_checker.sv
tb/tb.sv
